>>> src/hvr_pkg.sv
// Shared types and constants for the varispeed Hermite resampler.
// No dependencies; used by hermite_varispeed_resampler_top.
package hvr_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int FRAC_W     = 16;
    localparam int PHASE_W    = 23;
    localparam int STEP_W     = 19;
    localparam int LIMIT_W    = 7;
    localparam int OIDX_W     = 6;
    localparam int ACC_W      = 32;
    localparam int PROD_W     = ACC_W + FRAC_W + 1;
    localparam int TIDX_W     = 9;

    localparam logic [LIMIT_W-1:0] MAX_RESULTS = 7'd64;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 19'd65536;
    localparam logic [PROD_W-1:0]  ROUND_HALF  = PROD_W'(32768);

    localparam logic signed [ACC_W-1:0] SAT_MAX = 32'sd8388607;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -32'sd8388608;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_COEF,
        ST_MUL,
        ST_ADD,
        ST_FIN,
        ST_EMIT
    } t_state;

endpackage

>>> src/hermite_varispeed_resampler_top.sv
// Varispeed resampler with 4-point cubic Hermite interpolation, top level.
// Depends on hvr_pkg (types, constants) and hvr_ram (frame store).
//
//  channel   | ports                                          | flow control
//  ----------+------------------------------------------------+----------------------
//  frame in  | start, i_left/right_sample, i_last_frame,      | taken on start & !busy
//            | i_output_limit                                 |
//  result    | o_valid, o_left/right_out, o_frame_index,      | one-cycle strobe
//            | o_last_out                                     |
//  config    | i_cfg_we, i_cfg_wdata (step size)              | write on i_cfg_we
//
// A frame without the last mark leaves the block idle. A last frame starts output generation:
// each output frame runs a check, the four frame-store reads through its single registered
// read port, the coefficient and multiply-add steps per channel on the shared multiplier,
// and the strobe; one closing check follows. Synchronous active-low reset clears the frame
// count and phase and sets the step size to 65536; the store needs no clearing. The receiver
// cannot stall results.
module hermite_varispeed_resampler_top #(
    parameter int MAX_FRAMES = 64,
    parameter int CHANNELS   = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [hvr_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic signed [hvr_pkg::SAMPLE_W-1:0] i_right_sample,
    input  logic                                i_last_frame,
    input  logic [hvr_pkg::LIMIT_W-1:0]         i_output_limit,
    input  logic                                i_cfg_we,
    input  logic [hvr_pkg::STEP_W-1:0]          i_cfg_wdata,
    output logic                                o_valid,
    output logic signed [hvr_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [hvr_pkg::SAMPLE_W-1:0] o_right_out,
    output logic [hvr_pkg::OIDX_W-1:0]          o_frame_index,
    output logic                                o_last_out
);

    localparam int AW  = $clog2(MAX_FRAMES);
    localparam int CW  = $clog2(MAX_FRAMES + 1);
    localparam int DW  = CHANNELS * hvr_pkg::SAMPLE_W;
    localparam int SW  = hvr_pkg::SAMPLE_W;
    localparam int PW  = hvr_pkg::PHASE_W;
    localparam int FW  = hvr_pkg::FRAC_W;
    localparam int AC  = hvr_pkg::ACC_W;
    localparam int TW  = hvr_pkg::TIDX_W;
    localparam int LW  = hvr_pkg::LIMIT_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAMES);

    hvr_pkg::t_state r_state, n_state;

    // control state
    logic [CW-1:0]            r_count;
    logic [PW-1:0]            r_phase;
    logic [hvr_pkg::STEP_W-1:0] r_step_size;
    logic [PW-1:0]            r_pos;
    logic [LW-1:0]            r_limit;
    logic [LW-1:0]            r_n;
    logic [2:0]               r_tcnt;
    logic [1:0]               r_pass;
    logic                     r_ch;

    // datapath
    logic [DW-1:0]            r_tap [4];
    logic signed [AC-1:0]     r_c1, r_c2, r_acc;
    logic signed [hvr_pkg::PROD_W-1:0] r_prod;
    logic signed [SW-1:0]     r_left_res, r_right_res;

    logic                     accept, store_wr;
    logic [DW-1:0]            wr_word, rd_word;
    logic [PW:0]              end_pos, pos_ext, pos_next;
    logic                     more;
    logic signed [TW-1:0]     tidx, tclamp;
    logic signed [TW-1:0]     len_s;
    logic [AW-1:0]            rd_addr;
    logic                     rd_en;
    logic signed [AC-1:0]     xm1, x0, x1, x2, dx, coef, rnd, half;
    logic signed [hvr_pkg::PROD_W-1:0] prod_w, prod_r;
    logic signed [SW-1:0]     sat;
    logic [LW-1:0]            lim_in;

    assign accept   = start && !busy;
    assign store_wr = accept && (r_count < MAX_CNT);
    assign wr_word  = DW'({i_right_sample, i_left_sample});
    assign lim_in   = (i_output_limit > hvr_pkg::MAX_RESULTS) ? hvr_pkg::MAX_RESULTS
                                                             : i_output_limit;

    assign end_pos  = (PW + 1)'(r_count) << FW;
    assign pos_ext  = {1'b0, r_pos};
    assign pos_next = pos_ext + (PW + 1)'(r_step_size);
    assign more     = (r_n < r_limit) && (pos_ext < end_pos);

    // neighbor index i-1+t, clamped into the block
    assign len_s  = TW'(r_count);
    assign tidx   = TW'(r_pos[PW-1:FW]) + TW'(r_tcnt) - TW'(1);
    assign tclamp = (tidx < 0) ? TW'(0) : ((tidx >= len_s) ? len_s - TW'(1) : tidx);
    assign rd_addr = tclamp[AW-1:0];
    assign rd_en   = (r_state == hvr_pkg::ST_READ) && (r_tcnt < 3'd4);

    hvr_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_FRAMES)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (store_wr),
        .i_wr_addr(r_count[AW-1:0]),
        .i_wr_data(wr_word),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_word)
    );

    // channel select from the tap words
    function automatic logic signed [AC-1:0] pick(input logic [DW-1:0] w, input logic ch);
        logic [2*SW-1:0] wide;
        wide = (2 * SW)'(w);
        pick = ch ? AC'($signed(wide[2*SW-1:SW])) : AC'($signed(wide[SW-1:0]));
    endfunction

    assign xm1 = pick(r_tap[0], r_ch);
    assign x0  = pick(r_tap[1], r_ch);
    assign x1  = pick(r_tap[2], r_ch);
    assign x2  = pick(r_tap[3], r_ch);
    assign dx  = x0 - x1;

    assign prod_w = r_acc * $signed({1'b0, r_pos[FW-1:0]});
    assign prod_r = r_prod + $signed(hvr_pkg::ROUND_HALF);
    assign rnd    = AC'(prod_r >>> FW);
    assign half   = (r_acc + AC'(1)) >>> 1;
    assign sat    = (half > hvr_pkg::SAT_MAX) ? SW'(hvr_pkg::SAT_MAX) :
                    (half < hvr_pkg::SAT_MIN) ? SW'(hvr_pkg::SAT_MIN) : SW'(half);

    always_comb begin
        case (r_pass)
            2'd0:    coef = r_c2;
            2'd1:    coef = r_c1;
            default: coef = x0 <<< 1;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hvr_pkg::ST_IDLE: begin
                if (accept && i_last_frame) n_state = hvr_pkg::ST_CHECK;
            end
            hvr_pkg::ST_CHECK: begin
                n_state = more ? hvr_pkg::ST_READ : hvr_pkg::ST_IDLE;
            end
            hvr_pkg::ST_READ: begin
                if (r_tcnt == 3'd4) n_state = hvr_pkg::ST_COEF;
            end
            hvr_pkg::ST_COEF: n_state = hvr_pkg::ST_MUL;
            hvr_pkg::ST_MUL:  n_state = hvr_pkg::ST_ADD;
            hvr_pkg::ST_ADD: begin
                n_state = (r_pass == 2'd2) ? hvr_pkg::ST_FIN : hvr_pkg::ST_MUL;
            end
            hvr_pkg::ST_FIN: begin
                n_state = (CHANNELS > 1 && !r_ch) ? hvr_pkg::ST_COEF : hvr_pkg::ST_EMIT;
            end
            hvr_pkg::ST_EMIT: n_state = hvr_pkg::ST_CHECK;
            default:          n_state = hvr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy    = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            hvr_pkg::ST_IDLE: busy    = 1'b0;
            hvr_pkg::ST_EMIT: o_valid = 1'b1;
            default: begin
                busy    = 1'b1;
                o_valid = 1'b0;
            end
        endcase
    end

    assign o_left_out    = r_left_res;
    assign o_right_out   = (CHANNELS > 1) ? r_right_res : '0;
    assign o_frame_index = r_n[hvr_pkg::OIDX_W-1:0];
    assign o_last_out    = ((r_n + LW'(1)) >= r_limit) || (pos_next >= end_pos);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hvr_pkg::ST_IDLE;
            r_count     <= '0;
            r_phase     <= '0;
            r_step_size <= hvr_pkg::STEP_RESET;
            r_tcnt      <= '0;
            r_pass      <= '0;
            r_ch        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_step_size <= i_cfg_wdata;
            case (r_state)
                hvr_pkg::ST_IDLE: begin
                    if (store_wr) r_count <= r_count + CW'(1);
                end
                hvr_pkg::ST_CHECK: begin
                    r_tcnt <= '0;
                    r_ch   <= 1'b0;
                    if (!more) begin
                        // close the block: wrap phase once, drop the stored frames
                        r_phase <= (pos_ext >= end_pos) ? PW'(pos_ext - end_pos) : r_pos;
                        r_count <= '0;
                    end
                end
                hvr_pkg::ST_READ: r_tcnt <= r_tcnt + 3'd1;
                hvr_pkg::ST_COEF: r_pass <= '0;
                hvr_pkg::ST_ADD:  r_pass <= r_pass + 2'd1;
                hvr_pkg::ST_FIN:  r_ch   <= 1'b1;
                default: begin
                    r_tcnt <= r_tcnt;
                end
            endcase
        end
    end

    // position, output counter and arithmetic
    always_ff @(posedge i_clk) begin
        case (r_state)
            hvr_pkg::ST_IDLE: begin
                r_pos   <= r_phase;
                r_limit <= lim_in;
                r_n     <= '0;
            end
            hvr_pkg::ST_READ: begin
                // read data arrives from the registered read port in the cycle after its address
                if (r_tcnt != 3'd0) r_tap[2'(r_tcnt - 3'd1)] <= rd_word;
            end
            hvr_pkg::ST_COEF: begin
                r_c1  <= x1 - xm1;
                r_c2  <= (xm1 <<< 1) - (x0 <<< 2) - x0 + (x1 <<< 2) - x2;
                r_acc <= (x2 - xm1) + (dx <<< 1) + dx;
            end
            hvr_pkg::ST_MUL: r_prod <= prod_w;
            hvr_pkg::ST_ADD: r_acc  <= coef + rnd;
            hvr_pkg::ST_FIN: begin
                if (r_ch) r_right_res <= sat;
                else      r_left_res  <= sat;
            end
            hvr_pkg::ST_EMIT: begin
                r_n   <= r_n + LW'(1);
                r_pos <= PW'(pos_next);
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

endmodule

>>> src/hvr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hvr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
